/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
// Clocked property checks with and without a reset qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MTC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mtc_pkg.sv */
// Shared types, codes and arithmetic for the Munsell to CIE interpolator.
// No dependencies.
package mtc_pkg;

  localparam int HUE_STEPS = 40;
  localparam int HUE_SPAN  = 51200;   // HUE_STEPS * 1280, doubled hue in 1/1280 step
  localparam int ROW_W     = 10;      // width of value_row * HUE_STEPS + hue_step
  localparam int LUM_TERMS = 5;
  localparam int ACC_W     = 50;      // luminance accumulator
  localparam int PROD_W    = 63;      // accumulator times value

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_MISS  = 2'd2;

  localparam logic [2:0] CFG_NEUTRAL_X = 3'd0;
  localparam logic [2:0] CFG_NEUTRAL_Y = 3'd1;
  localparam logic [2:0] CFG_LUM_ONE   = 3'd2;
  localparam logic [2:0] CFG_LUM_TWO   = 3'd3;
  localparam logic [2:0] CFG_LUM_THREE = 3'd4;
  localparam logic [2:0] CFG_LUM_FOUR  = 3'd5;
  localparam logic [2:0] CFG_LUM_FIVE  = 3'd6;

  typedef logic [LUM_TERMS-1:0][31:0] lum_coef_t;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_PREP  = 9'b000000100,
    ST_WGT   = 9'b000001000,
    ST_READ  = 9'b000010000,
    ST_LV0   = 9'b000100000,
    ST_LV1   = 9'b001000000,
    ST_LC    = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  // round-half-up of (p0*65536 + (p1-p0)*w) / 65536
  function automatic logic [15:0] lerp16(input logic [15:0] p0, input logic [15:0] p1,
                                         input logic [15:0] w);
    logic signed [16:0] d;
    logic signed [33:0] prod;
    logic signed [34:0] sum;
    d    = $signed({1'b0, p1}) - $signed({1'b0, p0});
    prod = 34'(d) * 34'($signed({1'b0, w}));
    sum  = $signed({3'b000, p0, 16'h0000}) + 35'(prod) + 35'sd32768;
    return sum[31:16];
  endfunction

endpackage

/* sv/munsell_to_cie_interpolator.sv */
// Top level: Munsell to CIE x,y,Y converter with a loadable chromaticity table.
// Depends on mtc_pkg, mtc_ram and mtc_lum.
//
// Input channel (in_valid_i / in_stall_o): cmd_i = load writes one table entry
// at (load_value_row_i, load_hue_step_i, load_chroma_step_i) if in range and gives no
// result; cmd_i = convert gives one result on the output channel
// (out_valid_o / out_stall_i) with cie_x_o, cie_y_o, luminance_o, status_o.
// A load is written to the table as it is taken. A convert passes from its beat
// to the result register through the setup states PREP and WGT, eight corner reads
// from the single table RAM port plus the read latency, the lerp states LV0, LV1, LC
// and the output load in DONE. A range error skips WGT and the reads for DONE.
// Luminance runs alongside in a five-step Horner unit.
// The input stalls while a convert is in flight. A finished result waits in
// the output register while the receiver stalls; loads are still taken then,
// a further convert holds in its final cycle until the register frees.
// After reset the table is swept to zero, one entry a cycle, with the input stalled.
// Configuration writes are taken at any time, including during the sweep.
module munsell_to_cie_interpolator import mtc_pkg::*; #(
  parameter int VALUE_ROWS   = 16,
  parameter int CHROMA_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [14:0] hue_i,
  input  logic [11:0] munsell_value_i,
  input  logic [13:0] chroma_i,
  input  logic [3:0]  load_value_row_i,
  input  logic [5:0]  load_hue_step_i,
  input  logic [3:0]  load_chroma_step_i,
  input  logic [15:0] load_x_i,
  input  logic [15:0] load_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cie_x_o,
  output logic [15:0] cie_y_o,
  output logic [15:0] luminance_o,
  output logic [1:0]  status_o
);

  localparam int DEPTH = VALUE_ROWS * HUE_STEPS * CHROMA_STEPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CS_W  = $clog2(CHROMA_STEPS);
  localparam int FW    = ROW_W + CS_W;

  function automatic logic [AW-1:0] tab_addr(input logic [3:0] v, input logic [5:0] h,
                                             input logic [3:0] c);
    logic [ROW_W-1:0] row;
    logic [FW-1:0]    full;
    row  = ROW_W'(v) * ROW_W'(HUE_STEPS) + ROW_W'(h);
    full = FW'(row) * FW'(CHROMA_STEPS) + FW'(c);
    return full[AW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [AW-1:0] clr_addr_q;
  logic [15:0]   nx_q, ny_q;
  lum_coef_t     coef_q;

  logic [14:0] hue_q;
  logic [11:0] val_q;
  logic [13:0] chr_q;
  logic [5:0]  hs0_q, hs1_q;
  logic [10:0] frac_q;
  logic [15:0] hw_q, vw_q, cw_q;
  logic [3:0]  vs0_q, vs1_q, cs0_q, cs1_q;
  logic [3:0]  cnt_q;
  logic        miss_q;
  logic [15:0] first_x_q, first_y_q;
  logic [15:0] hx_q [4];
  logic [15:0] hy_q [4];
  logic [15:0] vx0_q, vx1_q, vy0_q, vy1_q;
  logic [15:0] res_x_q, res_y_q;
  logic [1:0]  res_status_q;

  logic        out_valid_q;
  logic [15:0] cie_x_q, cie_y_q, lum_out_q;
  logic [1:0]  status_q;

  logic in_accept, out_free, load_ok;

  // ram
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  // luminance
  logic        lum_start, lum_busy;
  logic [15:0] lum_val;

  // setup arithmetic
  logic [15:0] p2, p, q_mul, hs0_mul;
  logic [5:0]  hs0;
  logic [10:0] frac;
  logic [3:0]  vi;
  logic [4:0]  cs0_raw;
  logic        range_err;
  logic [18:0] m;
  logic [37:0] hw_mul;

  // corner handling
  logic [2:0]  s;
  logic [3:0]  cs_k;
  logic [15:0] cx, cy;
  logic        cur_miss;

  // shared lerp unit
  logic [15:0] la_x, lb_x, la_y, lb_y, lw, lr_x, lr_y;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_ok    = (5'(load_value_row_i) < 5'(VALUE_ROWS)) &&
                      (load_hue_step_i < 6'(HUE_STEPS)) &&
                      (5'(load_chroma_step_i) < 5'(CHROMA_STEPS));

  // hue wrap, step and fraction
  always_comb begin
    p2       = {hue_q, 1'b0};
    p        = (p2 >= 16'(HUE_SPAN)) ? p2 - 16'(HUE_SPAN) : p2;
    q_mul    = 16'(p[15:8]) * 16'd205;           // (p/256)/5
    hs0      = q_mul[15:10];
    hs0_mul  = 16'(hs0) * 16'd1280;
    frac     = 11'(p - hs0_mul);
    vi       = val_q[11:8];
    range_err = (vi == 4'd0) || ((5'(vi) - 5'd1) >= 5'(VALUE_ROWS));
    cs0_raw  = 5'(chr_q[13:9]);
    // round(frac*65536/1280) = floor((frac*256+2)/5)
    m        = {frac_q, 8'h00} + 19'd2;
    hw_mul   = 38'(m) * 38'd419431;
  end

  // corner in flight: read order keeps each hue pair together
  always_comb begin
    s        = 3'(cnt_q - 4'd1);
    cs_k     = s[1] ? cs1_q : cs0_q;
    if (cs_k == 4'd0) begin
      cx = nx_q;
      cy = ny_q;
    end else begin
      cx = ram_rdata[15:0];
      cy = ram_rdata[31:16];
    end
    cur_miss = (state_q == ST_READ) && (cnt_q != 4'd0) && (cs_k != 4'd0) &&
               ((ram_rdata[15:0] == 16'h0000) || (ram_rdata[31:16] == 16'h0000));
  end

  always_comb begin
    la_x = first_x_q;
    lb_x = cx;
    la_y = first_y_q;
    lb_y = cy;
    lw   = hw_q;
    case (state_q)
      ST_LV0: begin
        la_x = hx_q[0]; lb_x = hx_q[2]; la_y = hy_q[0]; lb_y = hy_q[2]; lw = vw_q;
      end
      ST_LV1: begin
        la_x = hx_q[1]; lb_x = hx_q[3]; la_y = hy_q[1]; lb_y = hy_q[3]; lw = vw_q;
      end
      ST_LC: begin
        la_x = vx0_q; lb_x = vx1_q; la_y = vy0_q; lb_y = vy1_q; lw = cw_q;
      end
      default: begin
      end
    endcase
    lr_x = lerp16(la_x, lb_x, lw);
    lr_y = lerp16(la_y, lb_y, lw);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tab_addr(load_value_row_i, load_hue_step_i, load_chroma_step_i);
    ram_wdata = {load_y_i, load_x_i};
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = 32'h0000_0000;
    end else if (in_accept && cmd_i == CMD_LOAD && load_ok) begin
      ram_we = 1'b1;
    end
    ram_re    = (state_q == ST_READ) && !cnt_q[3];
    ram_raddr = tab_addr(cnt_q[2] ? vs1_q : vs0_q, cnt_q[0] ? hs1_q : hs0_q,
                         cnt_q[1] ? cs1_q : cs0_q);
  end

  assign lum_start = (state_q == ST_PREP) && !range_err;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_addr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_accept && cmd_i == CMD_CONVERT) state_d = ST_PREP;
      ST_PREP:  state_d = range_err ? ST_DONE : ST_WGT;
      ST_WGT:   state_d = ST_READ;
      ST_READ: begin
        if (cnt_q == 4'd8) begin
          state_d = (miss_q || cur_miss) ? ST_DONE : ST_LV0;
        end
      end
      ST_LV0:   state_d = ST_LV1;
      ST_LV1:   state_d = ST_LC;
      ST_LC:    state_d = ST_DONE;
      ST_DONE:  if (!lum_busy && out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      nx_q        <= 16'h0000;
      ny_q        <= 16'h0000;
      coef_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (state_q == ST_DONE && !lum_busy && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NEUTRAL_X: nx_q      <= cfg_wdata_i[15:0];
          CFG_NEUTRAL_Y: ny_q      <= cfg_wdata_i[15:0];
          CFG_LUM_ONE:   coef_q[0] <= cfg_wdata_i;
          CFG_LUM_TWO:   coef_q[1] <= cfg_wdata_i;
          CFG_LUM_THREE: coef_q[2] <= cfg_wdata_i;
          CFG_LUM_FOUR:  coef_q[3] <= cfg_wdata_i;
          CFG_LUM_FIVE:  coef_q[4] <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && cmd_i == CMD_CONVERT) begin
      hue_q <= hue_i;
      val_q <= munsell_value_i;
      chr_q <= chroma_i;
    end
    unique case (state_q)
      ST_PREP: begin
        hs0_q  <= hs0;
        frac_q <= frac;
        vs0_q  <= vi - 4'd1;
        vs1_q  <= (5'(vi) >= 5'(VALUE_ROWS)) ? 4'(VALUE_ROWS - 1) : vi;
        cs0_q  <= (cs0_raw > 5'(CHROMA_STEPS - 1)) ? 4'(CHROMA_STEPS - 1) : cs0_raw[3:0];
        cs1_q  <= (cs0_raw >= 5'(CHROMA_STEPS - 1)) ? 4'(CHROMA_STEPS - 1) :
                  cs0_raw[3:0] + 4'd1;
        vw_q   <= {val_q[7:0], 8'h00};
        cw_q   <= {chr_q[8:0], 7'h00};
        res_x_q      <= 16'h0000;
        res_y_q      <= 16'h0000;
        res_status_q <= STAT_RANGE;
      end
      ST_WGT: begin
        hw_q   <= hw_mul[36:21];
        if (frac_q == 11'd0) begin
          hs1_q <= hs0_q;
        end else begin
          hs1_q <= (hs0_q == 6'(HUE_STEPS - 1)) ? 6'd0 : hs0_q + 6'd1;
        end
        cnt_q  <= 4'd0;
        miss_q <= 1'b0;
      end
      ST_READ: begin
        cnt_q <= cnt_q + 4'd1;
        if (cur_miss) begin
          miss_q <= 1'b1;
        end
        if (cnt_q != 4'd0) begin
          if (!s[0]) begin
            first_x_q <= cx;
            first_y_q <= cy;
          end else begin
            hx_q[0] <= hx_q[1]; hx_q[1] <= hx_q[2]; hx_q[2] <= hx_q[3]; hx_q[3] <= lr_x;
            hy_q[0] <= hy_q[1]; hy_q[1] <= hy_q[2]; hy_q[2] <= hy_q[3]; hy_q[3] <= lr_y;
          end
        end
        res_status_q <= STAT_MISS;
      end
      ST_LV0: begin
        vx0_q <= lr_x;
        vy0_q <= lr_y;
      end
      ST_LV1: begin
        vx1_q <= lr_x;
        vy1_q <= lr_y;
      end
      ST_LC: begin
        res_x_q      <= lr_x;
        res_y_q      <= lr_y;
        res_status_q <= STAT_OK;
      end
      ST_DONE: begin
        if (!lum_busy && out_free) begin
          cie_x_q   <= res_x_q;
          cie_y_q   <= res_y_q;
          status_q  <= res_status_q;
          lum_out_q <= (res_status_q == STAT_OK) ? lum_val : 16'h0000;
        end
      end
      default: begin
      end
    endcase
  end

  mtc_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  mtc_lum u_lum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lum_start),
    .value_i(val_q),
    .coef_i (coef_q),
    .busy_o (lum_busy),
    .lum_o  (lum_val)
  );

  assign out_valid_o = out_valid_q;
  assign cie_x_o     = cie_x_q;
  assign cie_y_o     = cie_y_q;
  assign luminance_o = lum_out_q;
  assign status_o    = status_q;

endmodule

/* sv/mtc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mtc_lum.sv */
// Luminance polynomial of Munsell value, Horner form, one term per cycle.
// Depends on mtc_pkg.
module mtc_lum import mtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [11:0] value_i,
  input  lum_coef_t   coef_i,
  output logic        busy_o,
  output logic [15:0] lum_o
);

  logic                     busy_q;
  logic [2:0]               step_q;
  logic [11:0]              v_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic [15:0]              lum_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd8;
  logic signed [PROD_W-1:0] rnd24;
  logic signed [ACC_W-1:0]  coef_ext;
  logic [2:0]               coef_idx;

  always_comb begin
    prod     = PROD_W'(acc_q) * PROD_W'($signed({1'b0, v_q}));
    rnd8     = (prod + PROD_W'(128)) >>> 8;
    rnd24    = (prod + (PROD_W'(1) <<< 23)) >>> 24;
    // steps 0..3 use coefficients 3..0; the final step takes no coefficient
    coef_idx = 3'd3 - {1'b0, step_q[1:0]};
    coef_ext = $signed(ACC_W'(coef_i[coef_idx]));
    // even steps subtract (fourth and square terms), odd steps add
    if (!step_q[0]) begin
      acc_d = ACC_W'(rnd8) - coef_ext;
    end else begin
      acc_d = ACC_W'(rnd8) + coef_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= 3'd0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd4) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      acc_q <= $signed(ACC_W'(coef_i[LUM_TERMS-1]));
    end else if (busy_q) begin
      if (step_q == 3'd4) begin
        if (rnd24 < 0) begin
          lum_q <= 16'h0000;
        end else if (rnd24 > PROD_W'(65535)) begin
          lum_q <= 16'hffff;
        end else begin
          lum_q <= rnd24[15:0];
        end
      end else begin
        acc_q <= acc_d;
      end
    end
  end

  assign busy_o = busy_q;
  assign lum_o  = lum_q;

endmodule

/* sv/mtc_checker.sv */
// Port-level checks for the Munsell to CIE interpolator, bound to the top.
// Depends on mtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtc_checker import mtc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] cie_x_o,
  input logic [15:0] cie_y_o,
  input logic [15:0] luminance_o,
  input logic [1:0]  status_o
);

  // table sweep keeps the input closed while in reset
  `MTC_ASSERT_ALWAYS(a_reset_stall, clk_i, !rst_ni |=> in_stall_o, "input open in reset")

  // an error beat carries no color
  `MTC_ASSERT(a_err_zero, clk_i, rst_ni,
    (out_valid_o && status_o != STAT_OK) |->
      (cie_x_o == 16'h0000 && cie_y_o == 16'h0000 && luminance_o == 16'h0000),
    "error result with nonzero payload")

  `MTC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o, "valid dropped")

  `MTC_ASSERT(a_out_stable, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> ($stable(cie_x_o) && $stable(cie_y_o) && $stable(status_o)),
    "stalled result changed")

endmodule

bind munsell_to_cie_interpolator mtc_checker u_mtc_checker (.*);
